// ----- src/calendar_day_adder_assert.svh -----
// ----------------------------------------------------------------------------
// Calendar day adder assertion macros
// Implication checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DAY_ADDER_ASSERT_SVH
`define CALENDAR_DAY_ADDER_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CDA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar_day_adder: assertion failed");
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CDA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar_day_adder: assertion failed");
`else
`define CDA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CDA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/cda_pkg.sv -----
// ----------------------------------------------------------------------------
// Calendar day adder package
// Shared widths, calendar constants, month table and the result type.
// ----------------------------------------------------------------------------
package cda_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int INC_IN_W = 12;
    localparam int CENT_W  = 7;

    localparam int DAY_COUNT_WIDTH_DEF = 12;

    localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_MIN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [DAY_W-1:0]   DAY_MIN    = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LONG   = 5'd31;
    localparam logic [DAY_W-1:0]   FEB_LEAP   = 5'd29;
    localparam logic [DAY_W-1:0]   FEB_COMMON = 5'd28;
    localparam logic [CENT_W-1:0]  CENT_LAST  = 7'd99;

    // Reset date 2025-05-12, with the year also split into centuries and rest.
    localparam logic [YEAR_W-1:0]  RST_YEAR    = 14'd2025;
    localparam logic [MONTH_W-1:0] RST_MONTH   = 4'd5;
    localparam logic [DAY_W-1:0]   RST_DAY     = 5'd12;
    localparam logic [CENT_W-1:0]  RST_YEAR_HI = 7'd20;
    localparam logic [CENT_W-1:0]  RST_YEAR_LO = 7'd25;

    // Division by 100 for years up to 9999: (y * 5243) >> 19.
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int DIV100_PW    = 27;
    localparam logic [YEAR_W-1:0] CENTURY = 14'd100;

    // Days per month, January first; February holds its common-year length.
    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               overflow;
    } cda_result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cda_status_t;

endpackage

// ----- src/cda_month_len.sv -----
// ----------------------------------------------------------------------------
// Calendar day adder month length
// Length of a month from the table, with the leap rule for February.
// ----------------------------------------------------------------------------
module cda_month_len
    import cda_pkg::*;
(
    input  logic [MONTH_W-1:0] month,
    input  logic [CENT_W-1:0]  year_lo,
    input  logic [CENT_W-1:0]  year_hi,
    output logic [DAY_W-1:0]   len
);

    logic leap;
    logic [MONTH_W-1:0] idx;

    // A year is a leap year when it divides by 4 but not by 100, or by 400.
    // The year divides by 4 exactly when its last two digits do.
    assign leap = (year_lo[1:0] == 2'b00) &&
                  ((year_lo != '0) || (year_hi[1:0] == 2'b00));

    assign idx = month - MONTH_MIN;

    // Table lookup; months outside 1..12 read as long months.
    always_comb
    begin
        if (month < MONTH_MIN || month > MONTH_DEC)
        begin
            len = DAY_LONG;
        end
        else if (month == MONTH_FEB)
        begin
            len = leap ? FEB_LEAP : FEB_COMMON;
        end
        else
        begin
            len = MONTH_LEN[idx];
        end
    end

endmodule

// ----- src/cda_engine.sv -----
// ----------------------------------------------------------------------------
// Calendar day adder engine
// Holds the current date and steps it one month per cycle through a shared
// compare and subtract unit under a small sequencer.
// ----------------------------------------------------------------------------
module cda_engine
    import cda_pkg::*;
#(
    parameter int DAY_COUNT_WIDTH = DAY_COUNT_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                mode,
    input  logic [YEAR_W-1:0]   set_year,
    input  logic [MONTH_W-1:0]  set_month,
    input  logic [DAY_W-1:0]    set_day,
    input  logic [INC_IN_W-1:0] days_to_add,
    input  logic                res_ready,
    output cda_status_t         status,
    output cda_result_t         result
);

    localparam int INC_W = (DAY_COUNT_WIDTH < INC_IN_W) ? DAY_COUNT_WIDTH : INC_IN_W;
    localparam int SUM_W = INC_W + 1;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_LOAD_LO = 5'b00010,
        ST_LOAD_DY = 5'b00100,
        ST_ADVANCE = 5'b01000,
        ST_DONE    = 5'b10000
    } cda_state_t;

    cda_state_t state_reg, state_next;

    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [DAY_W-1:0]   day_reg, day_next;
    logic [CENT_W-1:0]  year_lo_reg, year_lo_next;
    logic [CENT_W-1:0]  year_hi_reg, year_hi_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               ovf_reg, ovf_next;

    logic [YEAR_W-1:0]     year_clamp;
    logic [MONTH_W-1:0]    month_clamp;
    logic [DIV100_PW-1:0]  div_prod;
    logic [YEAR_W-1:0]     lo_full;
    logic [DAY_W-1:0]      len;
    logic [SUM_W-1:0]      len_ext;
    logic                  fits;

    // Shared month length lookup on the working date.
    cda_month_len u_month_len (
        .month   (month_reg),
        .year_lo (year_lo_reg),
        .year_hi (year_hi_reg),
        .len     (len)
    );

    // Clamp the year and month of a load, and split off the centuries.
    always_comb
    begin
        if (set_year == '0)
        begin
            year_clamp = YEAR_MIN;
        end
        else if (set_year > YEAR_MAX)
        begin
            year_clamp = YEAR_MAX;
        end
        else
        begin
            year_clamp = set_year;
        end

        if (set_month == '0)
        begin
            month_clamp = MONTH_MIN;
        end
        else if (set_month > MONTH_DEC)
        begin
            month_clamp = MONTH_DEC;
        end
        else
        begin
            month_clamp = set_month;
        end
    end

    assign div_prod = DIV100_PW'(year_clamp) * DIV100_PW'(DIV100_MUL);
    assign lo_full  = year_reg - YEAR_W'(year_hi_reg) * CENTURY;
    assign len_ext  = SUM_W'(len);
    assign fits     = (sum_reg <= len_ext);

    // Sequencer and datapath next state.
    always_comb
    begin
        state_next   = state_reg;
        year_next    = year_reg;
        month_next   = month_reg;
        day_next     = day_reg;
        year_lo_next = year_lo_reg;
        year_hi_next = year_hi_reg;
        sum_next     = sum_reg;
        ovf_next     = ovf_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ovf_next = 1'b0;
                    if (mode == 1'b0)
                    begin
                        year_next    = year_clamp;
                        month_next   = month_clamp;
                        year_hi_next = div_prod[DIV100_SHIFT +: CENT_W];
                        sum_next     = SUM_W'(set_day);
                        state_next   = ST_LOAD_LO;
                    end
                    else
                    begin
                        sum_next   = SUM_W'(day_reg) + SUM_W'(days_to_add[INC_W-1:0]);
                        state_next = ST_ADVANCE;
                    end
                end
            end
            ST_LOAD_LO:
            begin
                year_lo_next = lo_full[CENT_W-1:0];
                state_next   = ST_LOAD_DY;
            end
            ST_LOAD_DY:
            begin
                // Clamp the loaded day into the loaded month.
                if (sum_reg == '0)
                begin
                    day_next = DAY_MIN;
                end
                else if (!fits)
                begin
                    day_next = len;
                end
                else
                begin
                    day_next = sum_reg[DAY_W-1:0];
                end
                state_next = ST_DONE;
            end
            ST_ADVANCE:
            begin
                if (fits)
                begin
                    day_next   = sum_reg[DAY_W-1:0];
                    state_next = ST_DONE;
                end
                else if (month_reg == MONTH_DEC && year_reg == YEAR_MAX)
                begin
                    // Leaving the last representable year saturates the date.
                    month_next = MONTH_DEC;
                    day_next   = DAY_LONG;
                    ovf_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    sum_next = sum_reg - len_ext;
                    if (month_reg == MONTH_DEC)
                    begin
                        month_next = MONTH_MIN;
                        year_next  = year_reg + YEAR_W'(1);
                        if (year_lo_reg == CENT_LAST)
                        begin
                            year_lo_next = '0;
                            year_hi_next = year_hi_reg + CENT_W'(1);
                        end
                        else
                        begin
                            year_lo_next = year_lo_reg + CENT_W'(1);
                        end
                    end
                    else
                    begin
                        month_next = month_reg + MONTH_W'(1);
                    end
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Date state and sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            year_reg    <= RST_YEAR;
            month_reg   <= RST_MONTH;
            day_reg     <= RST_DAY;
            year_lo_reg <= RST_YEAR_LO;
            year_hi_reg <= RST_YEAR_HI;
        end
        else
        begin
            state_reg   <= state_next;
            year_reg    <= year_next;
            month_reg   <= month_next;
            day_reg     <= day_next;
            year_lo_reg <= year_lo_next;
            year_hi_reg <= year_hi_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        ovf_reg <= ovf_next;
    end

    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = (state_reg == ST_DONE);

    assign result.year     = year_reg;
    assign result.month    = month_reg;
    assign result.day      = day_reg;
    assign result.overflow = ovf_reg;

endmodule

// ----- src/calendar_day_adder.sv -----
// ----------------------------------------------------------------------------
// Calendar day adder
// Keeps a Gregorian date; each transfer loads a date or advances it by days.
//
//   Channel | Handshake                 | Payload
//   --------+---------------------------+--------------------------------------
//   input   | in_valid / in_stall       | mode, set_year, set_month, set_day,
//           |                           | days_to_add
//   output  | out_valid / out_stall     | out_year, out_month, out_day,
//           |                           | year_overflow
//
// A load passes through ST_LOAD_LO, ST_LOAD_DY and ST_DONE before its result
// is written to the output register. An advance steps N months (up to about
// 140 for a count of 4095); the single compare and subtract unit walks one
// month per cycle. in_stall is high from the transfer until the result is
// written, so the next item is taken in the cycle after that at the earliest.
// A result waits in the output register while the next item is worked on.
// Reset (rst_n, asynchronous) sets the date to 2025-05-12.
// ----------------------------------------------------------------------------
`include "calendar_day_adder_assert.svh"

module calendar_day_adder
    import cda_pkg::*;
#(
    parameter int DAY_COUNT_WIDTH = DAY_COUNT_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                mode,
    input  logic [YEAR_W-1:0]   set_year,
    input  logic [MONTH_W-1:0]  set_month,
    input  logic [DAY_W-1:0]    set_day,
    input  logic [INC_IN_W-1:0] days_to_add,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [YEAR_W-1:0]   out_year,
    output logic [MONTH_W-1:0]  out_month,
    output logic [DAY_W-1:0]    out_day,
    output logic                year_overflow
);

    cda_status_t status;
    cda_result_t result;
    logic        in_take;
    logic        res_ready;
    logic        out_valid_reg, out_valid_next;
    cda_result_t out_data_reg;
    logic        out_date_ok;
    logic        out_sat_ok;

    assign in_stall  = status.busy;
    assign in_take   = in_valid && !status.busy;
    assign res_ready = !out_valid_reg || !out_stall;

    cda_engine #(
        .DAY_COUNT_WIDTH (DAY_COUNT_WIDTH)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (in_take),
        .mode        (mode),
        .set_year    (set_year),
        .set_month   (set_month),
        .set_day     (set_day),
        .days_to_add (days_to_add),
        .res_ready   (res_ready),
        .status      (status),
        .result      (result)
    );

    // Output register: filled when the engine finishes and the slot is free or being read out.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (status.done && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.done && res_ready)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_year      = out_data_reg.year;
    assign out_month     = out_data_reg.month;
    assign out_day       = out_data_reg.day;
    assign year_overflow = out_data_reg.overflow;

    // Range and saturation checks on the delivered date.
    assign out_date_ok = (out_year != '0) && (out_year <= YEAR_MAX) &&
                         (out_month != '0) && (out_month <= MONTH_DEC) &&
                         (out_day != '0);
    assign out_sat_ok  = (out_year == YEAR_MAX) && (out_month == MONTH_DEC) &&
                         (out_day == DAY_LONG);

    // The engine goes busy right after it takes an item.
    `CDA_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_take, in_stall)
    // Every delivered date lies in the supported range.
    `CDA_ASSERT_IMP(a_date_range, clk, rst_n, out_valid, out_date_ok)
    // A saturated result always reads as the last day of year 9999.
    `CDA_ASSERT_IMP(a_sat_date, clk, rst_n, out_valid && year_overflow, out_sat_ok)

endmodule

// ----- test/calendar_day_adder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar day adder testbench
// A directed table runs first: reset date, field extremes, clamped loads, leap
// and century rules, December wrap and saturation past year 9999. Random loads
// and advances follow. An internal date tracker predicts every result. The
// sender works in bursts and the receiver stalls on its own pattern, with one
// long hold-off that backs the block up. Results are checked in order.
// ----------------------------------------------------------------------------
module calendar_day_adder_test;
    import cda_pkg::*;

    localparam int DAY_COUNT_WIDTH = DAY_COUNT_WIDTH_DEF;
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    localparam int RANDOM_ITEMS  = 1530;
    localparam int HOLD_START    = 2500;
    localparam int HOLD_CYCLES   = 600;
    localparam int DRAIN_CYCLES  = 20;
    localparam int TIMEOUT_NS    = 1600000;

    // One row of the directed table; want is used only when typed is set.
    typedef struct {
        logic                md;
        logic [YEAR_W-1:0]   y;
        logic [MONTH_W-1:0]  mo;
        logic [DAY_W-1:0]    d;
        logic [INC_IN_W-1:0] inc;
        bit                  typed;
        cda_result_t         want;
    } date_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                mode = MODE_LOAD;
    logic [YEAR_W-1:0]   set_year = '0;
    logic [MONTH_W-1:0]  set_month = '0;
    logic [DAY_W-1:0]    set_day = '0;
    logic [INC_IN_W-1:0] days_to_add = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [YEAR_W-1:0]   out_year;
    logic [MONTH_W-1:0]  out_month;
    logic [DAY_W-1:0]    out_day;
    logic                year_overflow;

    // Tracked date, expected results in transfer order, and the table.
    int          date_year;
    int          date_month;
    int          date_day;
    cda_result_t dates_due[$];
    date_row_t   date_rows[$];
    int          error_count = 0;
    int          burst_left = 0;

    // Receiver pattern state.
    int          rx_cycle = 0;
    int          rx_phase_left = 0;
    int          rx_pattern = 0;

    calendar_day_adder #(
        .DAY_COUNT_WIDTH (DAY_COUNT_WIDTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .set_year      (set_year),
        .set_month     (set_month),
        .set_day       (set_day),
        .days_to_add   (days_to_add),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_year      (out_year),
        .out_month     (out_month),
        .out_day       (out_day),
        .year_overflow (year_overflow)
    );

    always #1 clk = ~clk;

    // Gregorian leap rule, including the divisible-by-400 exception.
    function automatic bit is_leap_year(input int y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int days_in_month(input int y, input int m);
        if (m == int'(MONTH_FEB))
            return is_leap_year(y) ? int'(FEB_LEAP) : int'(FEB_COMMON);
        return int'(MONTH_LEN[m-1]);
    endfunction

    // Date after one item; the caller commits it to the tracked date.
    function automatic cda_result_t next_date(
        input logic                md,
        input logic [YEAR_W-1:0]   sy,
        input logic [MONTH_W-1:0]  sm,
        input logic [DAY_W-1:0]    sd,
        input logic [INC_IN_W-1:0] inc
    );
        cda_result_t r;
        int          y;
        int          m;
        int          d;
        int          len;
        bit          sat;
        sat = 1'b0;
        if (md == MODE_LOAD) begin
            // Out-of-range load fields clamp to the nearest legal value.
            y = int'(sy);
            m = int'(sm);
            d = int'(sd);
            if (y < int'(YEAR_MIN)) y = int'(YEAR_MIN);
            if (y > int'(YEAR_MAX)) y = int'(YEAR_MAX);
            if (m < int'(MONTH_MIN)) m = int'(MONTH_MIN);
            if (m > int'(MONTH_DEC)) m = int'(MONTH_DEC);
            len = days_in_month(y, m);
            if (d < int'(DAY_MIN)) d = int'(DAY_MIN);
            if (d > len) d = len;
        end
        else begin
            // Walk month by month; stepping past 9999 saturates the date.
            y = date_year;
            m = date_month;
            d = date_day + (int'(inc) & ((1 << DAY_COUNT_WIDTH) - 1));
            forever begin
                len = days_in_month(y, m);
                if (d <= len)
                    break;
                d -= len;
                m++;
                if (m > int'(MONTH_DEC)) begin
                    m = int'(MONTH_MIN);
                    y++;
                    if (y > int'(YEAR_MAX)) begin
                        y = int'(YEAR_MAX);
                        m = int'(MONTH_DEC);
                        d = int'(DAY_LONG);
                        sat = 1'b1;
                        break;
                    end
                end
            end
        end
        r.year     = YEAR_W'(y);
        r.month    = MONTH_W'(m);
        r.day      = DAY_W'(d);
        r.overflow = sat;
        return r;
    endfunction

    task automatic add_row(
        input logic                md,
        input logic [YEAR_W-1:0]   y,
        input logic [MONTH_W-1:0]  mo,
        input logic [DAY_W-1:0]    d,
        input logic [INC_IN_W-1:0] inc,
        input bit                  typed,
        input cda_result_t         want
    );
        date_row_t row;
        row.md    = md;
        row.y     = y;
        row.mo    = mo;
        row.d     = d;
        row.inc   = inc;
        row.typed = typed;
        row.want  = want;
        date_rows.push_back(row);
    endtask

    // Offer one item, hold it until the transfer, then queue its result.
    // Between bursts the sender may drop valid for a random gap.
    task automatic offer_item(
        input logic                md,
        input logic [YEAR_W-1:0]   y,
        input logic [MONTH_W-1:0]  mo,
        input logic [DAY_W-1:0]    d,
        input logic [INC_IN_W-1:0] inc,
        input cda_result_t         want
    );
        int gap;
        in_valid    <= 1'b1;
        mode        <= md;
        set_year    <= y;
        set_month   <= mo;
        set_day     <= d;
        days_to_add <= inc;
        do
            @(posedge clk);
        while (in_stall);
        dates_due.push_back(want);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Predict an item, commit the tracked date and send it.
    task automatic run_item(
        input logic                md,
        input logic [YEAR_W-1:0]   y,
        input logic [MONTH_W-1:0]  mo,
        input logic [DAY_W-1:0]    d,
        input logic [INC_IN_W-1:0] inc,
        input bit                  typed,
        input cda_result_t         want
    );
        cda_result_t pred;
        pred       = next_date(md, y, mo, d, inc);
        date_year  = int'(pred.year);
        date_month = int'(pred.month);
        date_day   = int'(pred.day);
        offer_item(md, y, mo, d, inc, typed ? want : pred);
    endtask

    // Stimulus: directed table first, then random loads and advances.
    initial begin : stimulus
        logic                md;
        logic [YEAR_W-1:0]   y;
        logic [MONTH_W-1:0]  mo;
        logic [DAY_W-1:0]    d;
        logic [INC_IN_W-1:0] inc;
        int                  sel;
        date_year  = int'(RST_YEAR);
        date_month = int'(RST_MONTH);
        date_day   = int'(RST_DAY);

        add_row(MODE_ADVANCE, 14'd0, 4'd0, 5'd0, 12'd0, 1, '{14'd2025, 4'd5, 5'd12, 1'b0});
        add_row(MODE_LOAD, 14'd0, 4'd0, 5'd0, 12'hfff, 1, '{14'd1, 4'd1, 5'd1, 1'b0});
        add_row(MODE_LOAD, 14'h3fff, 4'hf, 5'h1f, 12'd0, 1,
                '{14'd9999, 4'd12, 5'd31, 1'b0});
        add_row(MODE_ADVANCE, 14'h3fff, 4'hf, 5'h1f, 12'd1, 1,
                '{14'd9999, 4'd12, 5'd31, 1'b1});
        add_row(MODE_ADVANCE, 14'd0, 4'd0, 5'd0, 12'd0, 1, '{14'd9999, 4'd12, 5'd31, 1'b0});
        add_row(MODE_LOAD, 14'd2000, 4'd2, 5'd31, 12'd0, 1, '{14'd2000, 4'd2, 5'd29, 1'b0});
        add_row(MODE_LOAD, 14'd1900, 4'd2, 5'd30, 12'd0, 1, '{14'd1900, 4'd2, 5'd28, 1'b0});
        add_row(MODE_LOAD, 14'd2024, 4'd2, 5'd29, 12'd0, 1, '{14'd2024, 4'd2, 5'd29, 1'b0});
        add_row(MODE_ADVANCE, 14'd0, 4'd0, 5'd0, 12'd1, 1, '{14'd2024, 4'd3, 5'd1, 1'b0});
        add_row(MODE_LOAD, 14'd2023, 4'd2, 5'd29, 12'd0, 1, '{14'd2023, 4'd2, 5'd28, 1'b0});
        add_row(MODE_LOAD, 14'd2023, 4'd4, 5'd31, 12'd0, 1, '{14'd2023, 4'd4, 5'd30, 1'b0});
        add_row(MODE_ADVANCE, 14'd0, 4'd0, 5'd0, 12'hfff, 0, '0);
        add_row(MODE_LOAD, 14'd2023, 4'd12, 5'd31, 12'd0, 1,
                '{14'd2023, 4'd12, 5'd31, 1'b0});
        add_row(MODE_ADVANCE, 14'd0, 4'd0, 5'd0, 12'd1, 1, '{14'd2024, 4'd1, 5'd1, 1'b0});
        add_row(MODE_LOAD, 14'd2100, 4'd2, 5'd28, 12'd0, 1, '{14'd2100, 4'd2, 5'd28, 1'b0});
        add_row(MODE_ADVANCE, 14'd0, 4'd0, 5'd0, 12'd1, 1, '{14'd2100, 4'd3, 5'd1, 1'b0});
        add_row(MODE_LOAD, 14'd2400, 4'd2, 5'd28, 12'd0, 1, '{14'd2400, 4'd2, 5'd28, 1'b0});
        add_row(MODE_ADVANCE, 14'd0, 4'd0, 5'd0, 12'd1, 1, '{14'd2400, 4'd2, 5'd29, 1'b0});
        add_row(MODE_LOAD, 14'd9990, 4'd1, 5'd1, 12'd0, 1, '{14'd9990, 4'd1, 5'd1, 1'b0});
        add_row(MODE_ADVANCE, 14'd0, 4'd0, 5'd0, 12'hfff, 1,
                '{14'd9999, 4'd12, 5'd31, 1'b1});
        add_row(MODE_LOAD, 14'd1, 4'd1, 5'd1, 12'hfff, 1, '{14'd1, 4'd1, 5'd1, 1'b0});
        add_row(MODE_ADVANCE, 14'h2aaa, 4'ha, 5'h15, 12'hfff, 0, '0);
        add_row(MODE_LOAD, 14'd5000, 4'd7, 5'd0, 12'd0, 1, '{14'd5000, 4'd7, 5'd1, 1'b0});
        add_row(MODE_ADVANCE, 14'h1555, 4'h5, 5'h0a, 12'd100, 0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (date_rows[i])
            run_item(date_rows[i].md, date_rows[i].y, date_rows[i].mo, date_rows[i].d,
                     date_rows[i].inc, date_rows[i].typed, date_rows[i].want);

        // Random part: mostly advances, with loads aimed at century years,
        // the top of the year range, month ends and clamped fields.
        repeat (RANDOM_ITEMS) begin
            md  = ($urandom_range(0, 99) < 30) ? MODE_LOAD : MODE_ADVANCE;
            sel = $urandom_range(0, 99);
            if (sel < 45)
                y = YEAR_W'($urandom_range(1, 9999));
            else if (sel < 60)
                y = YEAR_W'($urandom_range(9980, 9999));
            else if (sel < 75)
                y = YEAR_W'($urandom_range(1, 99) * 100);
            else if (sel < 90)
                y = YEAR_W'($urandom_range(0, 16383));
            else
                y = YEAR_W'($urandom_range(0, 5));
            mo = ($urandom_range(0, 4) == 0) ? MONTH_W'($urandom_range(0, 15))
                                             : MONTH_W'($urandom_range(1, 12));
            d  = ($urandom_range(0, 2) == 0) ? DAY_W'($urandom_range(28, 31))
                                             : DAY_W'($urandom_range(0, 31));
            sel = $urandom_range(0, 99);
            if (sel < 45)
                inc = INC_IN_W'($urandom_range(0, 40));
            else if (sel < 65)
                inc = INC_IN_W'($urandom_range(0, 4095));
            else if (sel < 75)
                inc = '1;
            else if (sel < 90)
                inc = INC_IN_W'($urandom_range(0, 400));
            else
                inc = '0;
            run_item(md, y, mo, d, inc, 0, '0);
        end
        in_valid <= 1'b0;

        // Drain every pending result, then watch a little longer.
        while (dates_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver stall: random phases of no stall, light, heavy and periodic
    // stalling, plus one long hold-off that fills the block up.
    initial begin
        while (!rst_n)
            @(posedge clk);
        forever begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle == HOLD_START) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_cycle += HOLD_CYCLES;
            end
            else begin
                if (rx_phase_left == 0) begin
                    rx_pattern    = $urandom_range(0, 3);
                    rx_phase_left = $urandom_range(20, 200);
                end
                rx_phase_left--;
                case (rx_pattern)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 99) < 30);
                    2:       out_stall <= ($urandom_range(0, 99) < 70);
                    default: out_stall <= ((rx_cycle % 8) < 3);
                endcase
            end
        end
    end

    // Compare each result transfer with the oldest expected date.
    always @(posedge clk) begin
        cda_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (dates_due.size() == 0) begin
                $error("result transfer with no expected date pending");
                error_count++;
            end
            else begin
                want = dates_due.pop_front();
                if (out_year !== want.year) begin
                    $error("out_year: expected %0d, got %0d", want.year, out_year);
                    error_count++;
                end
                if (out_month !== want.month) begin
                    $error("out_month: expected %0d, got %0d", want.month, out_month);
                    error_count++;
                end
                if (out_day !== want.day) begin
                    $error("out_day: expected %0d, got %0d", want.day, out_day);
                    error_count++;
                end
                if (year_overflow !== want.overflow) begin
                    $error("year_overflow: expected %0d, got %0d", want.overflow,
                           year_overflow);
                    error_count++;
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/cda_pkg.sv
src/cda_month_len.sv
src/cda_engine.sv
src/calendar_day_adder.sv
test/calendar_day_adder_test.sv
